// File: rtl/core/ufdq_pkg.sv
// Shared types and constants for the urgent-first deque.
`default_nettype none

package ufdq_pkg;

    localparam int ID_W   = 16;
    localparam int TIME_W = 8;
    localparam int OCC_W  = 5;

    localparam logic [TIME_W-1:0] THR_RESET = 8'd10;

    // Operation codes
    localparam logic [2:0] OP_SUBMIT   = 3'd0;
    localparam logic [2:0] OP_DISPATCH = 3'd1;
    localparam logic [2:0] OP_PEEK     = 3'd2;
    localparam logic [2:0] OP_CANCEL   = 3'd3;
    localparam logic [2:0] OP_LIST     = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dur;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HEAD,
        ST_SEARCH,
        ST_SHIFT,
        ST_LIST
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/ufdq_mem.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module ufdq_mem
    import ufdq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic [AW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/urgent_first_deque_with_cancel_unit.sv
// Top level: urgent-first circular deque with cancel, sequencer around the entry store.
//
// Channel  | Signals                                           | Handshake
// ---------+---------------------------------------------------+-------------------------
// command  | opcode, order_id, prep_time                       | start & !busy accepts
// result   | status, result_id, result_time, occupancy, last   | result_valid, one cycle
// config   | cfg_wr_data (urgent_threshold)                    | cfg_wr_en writes
//
// Path from start to result: submit, empty-queue ops and unused codes answer
// from EXEC; dispatch and peek pass on through HEAD; list gives N words (one per
// cycle, N = occupancy) from LIST; cancel walks SEARCH (one entry per cycle) to
// the match, then SHIFT moves later entries down. Store: one write, one read port.
// busy is high from the accepting edge until the final word is registered.
// Reset is asynchronous, active low; the store itself is not cleared.
// The receiver cannot stall: each word is shown for exactly one cycle.
`default_nettype none

module urgent_first_deque_with_cancel_unit
    import ufdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        opcode,
    input  wire logic [ID_W-1:0]   order_id,
    input  wire logic [TIME_W-1:0] prep_time,
    input  wire logic              cfg_wr_en,
    input  wire logic [TIME_W-1:0] cfg_wr_data,
    output logic                   result_valid,
    output logic [1:0]             status,
    output logic [ID_W-1:0]        result_id,
    output logic [TIME_W-1:0]      result_time,
    output logic [OCC_W-1:0]       occupancy,
    output logic                   last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // circular index step with wrap at DEPTH
    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] p);
        return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] p);
        return (p == '0) ? IW'(DEPTH - 1) : p - IW'(1);
    endfunction

    state_t            state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [TIME_W-1:0] tm_reg, tm_next;
    logic [TIME_W-1:0] thr_reg;
    logic [IW-1:0]     head_reg, head_next;
    logic [IW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     ptr_reg, ptr_next;      // walk position in search/shift/list
    logic [CW-1:0]     idx_reg, idx_next;      // entries visited so far
    entry_t            hit_reg, hit_next;      // cancelled entry

    logic              valid_reg;
    logic [1:0]        status_reg;
    entry_t            entry_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic              last_reg;

    // emission request from the sequencer
    logic              emit_valid;
    logic [1:0]        emit_status;
    entry_t            emit_entry;
    logic              emit_last;

    // store port
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    entry_t            mem_wdata;
    logic [IW-1:0]     mem_raddr;
    entry_t            mem_rdata;

    logic [CW-1:0]     idx_plus;
    logic [IW-1:0]     ptr_plus;
    logic [IW-1:0]     new_head;
    logic [IW-1:0]     new_tail;
    logic [CW+OCC_W-1:0] occ_ext;

    ufdq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign idx_plus = idx_reg + CW'(1);
    assign ptr_plus = idx_inc(ptr_reg);
    assign new_head = idx_dec(head_reg);
    assign new_tail = idx_inc(tail_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            thr_reg   <= THR_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            valid_reg <= emit_valid;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        id_reg  <= id_next;
        tm_reg  <= tm_next;
        ptr_reg <= ptr_next;
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        if (emit_valid)
        begin
            status_reg <= emit_status;
            entry_reg  <= emit_entry;
            occ_reg    <= occ_ext[OCC_W-1:0];
            last_reg   <= emit_last;
        end
    end

    assign occ_ext = {{OCC_W{1'b0}}, count_next};

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        tm_next     = tm_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        emit_valid  = 1'b0;
        emit_status = STAT_OK;
        emit_entry  = '0;
        emit_last   = 1'b1;
        mem_we      = 1'b0;
        mem_waddr   = ptr_reg;
        mem_wdata   = mem_rdata;
        mem_raddr   = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    id_next    = order_id;
                    tm_next    = prep_time;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                ptr_next   = head_reg;
                idx_next   = '0;
                state_next = ST_IDLE;
                if (op_reg == OP_SUBMIT)
                begin
                    emit_valid = 1'b1;
                    if (count_reg == CW'(DEPTH))
                    begin
                        emit_status = STAT_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = '{id: id_reg, dur: tm_reg};
                        count_next = count_reg + CW'(1);
                        if (count_reg == '0)
                        begin
                            mem_waddr = '0;
                            head_next = '0;
                            tail_next = '0;
                        end
                        else if (tm_reg <= thr_reg)
                        begin
                            mem_waddr = new_head;
                            head_next = new_head;
                        end
                        else
                        begin
                            mem_waddr = new_tail;
                            tail_next = new_tail;
                        end
                    end
                end
                else if (op_reg == OP_DISPATCH || op_reg == OP_PEEK ||
                         op_reg == OP_CANCEL || op_reg == OP_LIST)
                begin
                    if (count_reg == '0)
                    begin
                        emit_valid  = 1'b1;
                        emit_status = STAT_EMPTY;
                    end
                    else if (op_reg == OP_CANCEL)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else if (op_reg == OP_LIST)
                    begin
                        state_next = ST_LIST;
                    end
                    else
                    begin
                        state_next = ST_HEAD;
                    end
                end
                else
                begin
                    // unused code: plain ok
                    emit_valid = 1'b1;
                end
            end

            ST_HEAD:
            begin
                emit_valid = 1'b1;
                emit_entry = mem_rdata;
                state_next = ST_IDLE;
                if (op_reg == OP_DISPATCH)
                begin
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else
                    begin
                        head_next = idx_inc(head_reg);
                    end
                end
            end

            ST_SEARCH:
            begin
                // read next slot ahead; data for ptr_reg is on mem_rdata
                mem_raddr = ptr_plus;
                if (mem_rdata.id == id_reg)
                begin
                    hit_next = mem_rdata;
                    if (ptr_reg == tail_reg)
                    begin
                        emit_valid = 1'b1;
                        emit_entry = mem_rdata;
                        count_next = count_reg - CW'(1);
                        state_next = ST_IDLE;
                        if (count_reg == CW'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else
                        begin
                            tail_next = idx_dec(tail_reg);
                        end
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
                else if (idx_plus == count_reg)
                begin
                    emit_valid  = 1'b1;
                    emit_status = STAT_NOT_FOUND;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_plus;
                    idx_next = idx_plus;
                end
            end

            ST_SHIFT:
            begin
                // move entry at ptr+1 down into ptr
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                mem_raddr = idx_inc(ptr_plus);
                ptr_next  = ptr_plus;
                if (ptr_plus == tail_reg)
                begin
                    emit_valid = 1'b1;
                    emit_entry = hit_reg;
                    count_next = count_reg - CW'(1);
                    tail_next  = idx_dec(tail_reg);
                    state_next = ST_IDLE;
                end
            end

            ST_LIST:
            begin
                emit_valid = 1'b1;
                emit_entry = mem_rdata;
                emit_last  = (idx_plus == count_reg);
                mem_raddr  = ptr_plus;
                ptr_next   = ptr_plus;
                idx_next   = idx_plus;
                if (idx_plus == count_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign result_id    = entry_reg.id;
    assign result_time  = entry_reg.dur;
    assign occupancy    = occ_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the urgent-first deque with cancel.
`timescale 1ns / 100ps

module testbench;
    import ufdq_pkg::*;

    localparam int SLOTS           = 16;
    localparam int STALL_LIMIT     = 1000;  // cycles with no word moving either way
    localparam int SETTLE_CYCLES   = 40;    // longer than a cancel that walks the full store
    localparam int PHASES          = 7;
    localparam int WORDS_PER_PHASE = 40;
    localparam int DIRECTED_ROWS   = 23;

    // Codes the block treats as no-ops
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam entry_t NO_ENTRY = '0;

    // One result word as seen on the output ports
    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dur;
        logic [OCC_W-1:0]  occ;
        logic              last;
    } result_word_t;

    // Directed stimulus row; 'typed' rows carry their single expected word
    typedef struct packed {
        logic [2:0]        op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dur;
        logic              typed;
        logic [1:0]        status;
        logic [ID_W-1:0]   exp_id;
        logic [TIME_W-1:0] exp_dur;
        logic [OCC_W-1:0]  occ;
    } cmd_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        opcode;
    logic [ID_W-1:0]   order_id;
    logic [TIME_W-1:0] prep_time;
    logic              cfg_wr_en;
    logic [TIME_W-1:0] cfg_wr_data;
    logic              result_valid;
    logic [1:0]        status;
    logic [ID_W-1:0]   result_id;
    logic [TIME_W-1:0] result_time;
    logic [OCC_W-1:0]  occupancy;
    logic              last;

    // Shadow copy of the deque, kept in step with every accepted command
    entry_t            slot_mem [SLOTS];
    logic [3:0]        head_ptr;
    logic [3:0]        tail_ptr;
    int unsigned       held;
    logic [TIME_W-1:0] urgent_thr;

    result_word_t      expected_words [$];
    int unsigned       err_count = 0;
    int unsigned       stall_cycles = 0;

    // Walkthrough from reset (threshold 10): empty-queue ops, no-op codes, head and
    // tail inserts incl. duration equal to threshold, duplicate ids, cancel of a
    // middle, tail and head entry, and emptying both by dispatch and by cancel.
    cmd_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_DISPATCH,  16'h0000, 8'h00, 1'b1, STAT_EMPTY,     16'h0000, 8'h00, 5'd0},
        '{OP_PEEK,      16'hFFFF, 8'hFF, 1'b1, STAT_EMPTY,     16'h0000, 8'h00, 5'd0},
        '{OP_CANCEL,    16'h0000, 8'h00, 1'b1, STAT_EMPTY,     16'h0000, 8'h00, 5'd0},
        '{OP_LIST,      16'h0000, 8'h00, 1'b1, STAT_EMPTY,     16'h0000, 8'h00, 5'd0},
        '{OP_UNUSED_LO, 16'hFFFF, 8'hFF, 1'b1, STAT_OK,        16'h0000, 8'h00, 5'd0},
        '{OP_SUBMIT,    16'hFFFF, 8'hFF, 1'b1, STAT_OK,        16'h0000, 8'h00, 5'd1},
        '{OP_SUBMIT,    16'h0000, 8'h00, 1'b1, STAT_OK,        16'h0000, 8'h00, 5'd2},
        '{OP_SUBMIT,    16'h1234, THR_RESET, 1'b1, STAT_OK,    16'h0000, 8'h00, 5'd3},
        '{OP_SUBMIT,    16'h00AA, 8'd11, 1'b1, STAT_OK,        16'h0000, 8'h00, 5'd4},
        '{OP_PEEK,      16'h0000, 8'h00, 1'b1, STAT_OK,        16'h1234, THR_RESET, 5'd4},
        '{OP_LIST,      16'h0000, 8'h00, 1'b0, STAT_OK,        16'h0000, 8'h00, 5'd0},
        '{OP_SUBMIT,    16'h0000, 8'hC8, 1'b1, STAT_OK,        16'h0000, 8'h00, 5'd5},
        '{OP_UNUSED_HI, 16'h5A5A, 8'hA5, 1'b1, STAT_OK,        16'h0000, 8'h00, 5'd5},
        '{OP_CANCEL,    16'h5555, 8'h00, 1'b1, STAT_NOT_FOUND, 16'h0000, 8'h00, 5'd5},
        '{OP_CANCEL,    16'h0000, 8'h00, 1'b0, STAT_OK,        16'h0000, 8'h00, 5'd0},
        '{OP_LIST,      16'h0000, 8'h00, 1'b0, STAT_OK,        16'h0000, 8'h00, 5'd0},
        '{OP_CANCEL,    16'h0000, 8'h00, 1'b0, STAT_OK,        16'h0000, 8'h00, 5'd0},
        '{OP_CANCEL,    16'h1234, 8'h00, 1'b0, STAT_OK,        16'h0000, 8'h00, 5'd0},
        '{OP_DISPATCH,  16'h0000, 8'h00, 1'b0, STAT_OK,        16'h0000, 8'h00, 5'd0},
        '{OP_DISPATCH,  16'h0000, 8'h00, 1'b0, STAT_OK,        16'h0000, 8'h00, 5'd0},
        '{OP_SUBMIT,    16'h8001, 8'h0B, 1'b0, STAT_OK,        16'h0000, 8'h00, 5'd0},
        '{OP_CANCEL,    16'h8001, 8'h00, 1'b0, STAT_OK,        16'h0000, 8'h00, 5'd0},
        '{OP_PEEK,      16'h0000, 8'h00, 1'b1, STAT_EMPTY,     16'h0000, 8'h00, 5'd0}
    };

    urgent_first_deque_with_cancel_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .order_id     (order_id),
        .prep_time    (prep_time),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .status       (status),
        .result_id    (result_id),
        .result_time  (result_time),
        .occupancy    (occupancy),
        .last         (last)
    );

    always #5 clk = ~clk;

    // Queue one expected word; occupancy is whatever the shadow holds after the op
    function automatic void push_word(logic [1:0] st, entry_t ent, logic fin);
        result_word_t w;
        w.status = st;
        w.id     = ent.id;
        w.dur    = ent.dur;
        w.occ    = OCC_W'(held);
        w.last   = fin;
        expected_words.push_back(w);
    endfunction

    // Apply one accepted command to the shadow deque and queue the words it yields
    function automatic void predict_command(logic [2:0] op, logic [ID_W-1:0] id,
                                            logic [TIME_W-1:0] dur);
        entry_t     hit;
        logic [3:0] pos;
        logic [3:0] nxt;
        logic       found;
        int         k;
        case (op)
            OP_SUBMIT:
            begin
                if (held >= SLOTS)
                begin
                    push_word(STAT_FULL, NO_ENTRY, 1'b1);
                end
                else
                begin
                    if (held == 0)
                    begin
                        // first entry always lands in slot 0
                        head_ptr    = '0;
                        tail_ptr    = '0;
                        slot_mem[0] = '{id: id, dur: dur};
                    end
                    else if (dur <= urgent_thr)
                    begin
                        head_ptr           = head_ptr - 4'd1;
                        slot_mem[head_ptr] = '{id: id, dur: dur};
                    end
                    else
                    begin
                        tail_ptr           = tail_ptr + 4'd1;
                        slot_mem[tail_ptr] = '{id: id, dur: dur};
                    end
                    held++;
                    push_word(STAT_OK, NO_ENTRY, 1'b1);
                end
            end
            OP_DISPATCH, OP_PEEK:
            begin
                if (held == 0)
                begin
                    push_word(STAT_EMPTY, NO_ENTRY, 1'b1);
                end
                else
                begin
                    hit = slot_mem[head_ptr];
                    if (op == OP_DISPATCH)
                    begin
                        head_ptr = head_ptr + 4'd1;
                        held--;
                        if (held == 0)
                        begin
                            head_ptr = '0;
                            tail_ptr = '0;
                        end
                    end
                    push_word(STAT_OK, hit, 1'b1);
                end
            end
            OP_CANCEL:
            begin
                if (held == 0)
                begin
                    push_word(STAT_EMPTY, NO_ENTRY, 1'b1);
                end
                else
                begin
                    // first match from head; pos is left on it
                    found = 1'b0;
                    pos   = head_ptr;
                    for (k = 0; k < int'(held) && !found; k++)
                    begin
                        pos   = head_ptr + 4'(k);
                        found = (slot_mem[pos].id == id);
                    end
                    if (!found)
                    begin
                        push_word(STAT_NOT_FOUND, NO_ENTRY, 1'b1);
                    end
                    else
                    begin
                        hit = slot_mem[pos];
                        // close the hole: later entries move one slot toward head
                        while (pos != tail_ptr)
                        begin
                            nxt           = pos + 4'd1;
                            slot_mem[pos] = slot_mem[nxt];
                            pos           = nxt;
                        end
                        tail_ptr = tail_ptr - 4'd1;
                        held--;
                        if (held == 0)
                        begin
                            head_ptr = '0;
                            tail_ptr = '0;
                        end
                        push_word(STAT_OK, hit, 1'b1);
                    end
                end
            end
            OP_LIST:
            begin
                if (held == 0)
                begin
                    push_word(STAT_EMPTY, NO_ENTRY, 1'b1);
                end
                else
                begin
                    for (k = 0; k < int'(held); k++)
                    begin
                        push_word(STAT_OK, slot_mem[head_ptr + 4'(k)], k == int'(held) - 1);
                    end
                end
            end
            default:
            begin
                push_word(STAT_OK, NO_ENTRY, 1'b1);
            end
        endcase
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endfunction

    // Mostly short gaps, a few long ones, and occasional zero-gap runs
    int unsigned no_gap_left = 0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            no_gap_left = $urandom_range(8, 20);
            return 0;
        end
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Present one command word at the falling edge and hold it until accepted;
    // returns right after the accepting rising edge.
    task automatic issue(logic [2:0] op, logic [ID_W-1:0] id, logic [TIME_W-1:0] dur);
        @(negedge clk);
        start     <= 1'b1;
        opcode    <= op;
        order_id  <= id;
        prep_time <= dur;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause_cycles(int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Every word sent has come back and the block has dropped busy
    task automatic wait_idle();
        while (expected_words.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Threshold is only touched with the block quiet
    task automatic write_threshold(logic [TIME_W-1:0] value);
        pause_cycles(1);
        wait_idle();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        urgent_thr = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result checker: every strobed word must match the oldest expected one
    always @(posedge clk)
    begin : result_check
        result_word_t want;
        if (rst_n && result_valid)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected: status %0h id %0h",
                       status, result_id);
                err_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                compare_field("status",      want.status, status);
                compare_field("result_id",   want.id,     result_id);
                compare_field("result_time", want.dur,    result_time);
                compare_field("occupancy",   want.occ,    occupancy);
                compare_field("last",        want.last,   last);
            end
        end
    end

    // Watchdog: too long with neither a command accepted nor a result strobed
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        cmd_row_t          row;
        result_word_t      typed_word;
        logic [2:0]        op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] thr;
        logic              filling;
        int unsigned       r;
        int                p;
        int                n;

        // All inputs known from time zero, reset held low at first
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = OP_SUBMIT;
        order_id    = '0;
        prep_time   = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;

        head_ptr   = '0;
        tail_ptr   = '0;
        held       = 0;
        urgent_thr = THR_RESET;
        foreach (slot_mem[i])
            slot_mem[i] = NO_ENTRY;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk; typed rows replace the predicted word with the table value
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            issue(row.op, row.id, row.dur);
            predict_command(row.op, row.id, row.dur);
            if (row.typed)
            begin
                void'(expected_words.pop_back());
                typed_word.status = row.status;
                typed_word.id     = row.exp_id;
                typed_word.dur    = row.exp_dur;
                typed_word.occ    = row.occ;
                typed_word.last   = 1'b1;
                expected_words.push_back(typed_word);
            end
            pause_cycles(pick_gap());
        end

        // Random phases: each starts with a threshold write on a drained block.
        // Fill phases favour submits, drain phases favour dispatch and cancel.
        for (p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                thr = 8'd0;
            else if (p == 1)
                thr = 8'd255;
            else if (p == 2)
                thr = THR_RESET;
            else
                thr = 8'($urandom_range(0, 255));
            write_threshold(thr);
            filling = (p % 3) != 2;

            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < (filling ? 55 : 20))
                    op = OP_SUBMIT;
                else if (r < (filling ? 65 : 50))
                    op = OP_DISPATCH;
                else if (r < (filling ? 72 : 58))
                    op = OP_PEEK;
                else if (r < (filling ? 84 : 82))
                    op = OP_CANCEL;
                else if (r < 92)
                    op = OP_LIST;
                else
                    op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

                // small id pool makes duplicates; full-range ids toggle every bit
                if ($urandom_range(0, 1) == 0)
                    id = 16'($urandom_range(0, 7));
                else
                    id = 16'($urandom);
                if (op == OP_CANCEL && held > 0 && $urandom_range(0, 99) < 65)
                    id = slot_mem[head_ptr + 4'($urandom_range(0, held - 1))].id;

                // durations clustered on the threshold boundary
                case ($urandom_range(0, 3))
                    0:       dur = urgent_thr;
                    1:       dur = urgent_thr + 8'd1;
                    2:       dur = urgent_thr - 8'd1;
                    default: dur = 8'($urandom);
                endcase

                issue(op, id, dur);
                predict_command(op, id, dur);
                pause_cycles(pick_gap());
            end
        end

        // Drain: everything back, then a quiet stretch for stray words
        pause_cycles(1);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
